// File: hdl/bdeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared sizes, codes and controller/datapath interface types for the
// bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int VAL_W = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH_FRONT,
    ACT_PUSH_BACK,
    ACT_POP_FRONT,
    ACT_POP_BACK,
    ACT_DUMP_FIRST,
    ACT_DUMP_NEXT
  } act_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ECHO,
    SRC_MEM
  } src_t;

  typedef struct packed {
    act_t       act;
    logic       out_load;
    src_t       out_src;
    logic [1:0] out_status;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic dump_last;
  } sts_t;

endpackage

// File: hdl/bdeq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_ctrl
// Request sequencer: decodes the op, steps memory reads and dump entries,
// and holds the result until it is taken.
// ----------------------------------------------------------------------------
module bdeq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [2:0]        op,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output bdeq_pkg::cmd_t    cmd,
  input  bdeq_pkg::sts_t    sts
);
  import bdeq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_OUT   = 5'b00100,
    S_DREAD = 5'b01000,
    S_DOUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_OUT) || (state == S_DOUT);

  always_comb begin
    state_next     = state;
    cmd.act        = ACT_NONE;
    cmd.out_load   = 1'b0;
    cmd.out_src    = SRC_ZERO;
    cmd.out_status = ST_OK;
    cmd.out_last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              cmd.out_load = 1'b1;
              state_next   = S_OUT;
              if (sts.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.act     = (op == OP_PUSH_FRONT) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                cmd.out_src = SRC_ECHO;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (sts.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
                state_next     = S_OUT;
              end else begin
                cmd.act    = (op == OP_POP_FRONT) ? ACT_POP_FRONT : ACT_POP_BACK;
                state_next = S_READ;
              end
            end
            OP_DUMP: begin
              if (sts.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
                state_next     = S_OUT;
              end else begin
                cmd.act    = ACT_DUMP_FIRST;
                state_next = S_DREAD;
              end
            end
            default: ;  // unused codes: dropped
          endcase
        end
      end
      S_READ: begin
        cmd.out_load = 1'b1;
        cmd.out_src  = SRC_MEM;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      S_DREAD: begin
        cmd.out_load = 1'b1;
        cmd.out_src  = SRC_MEM;
        cmd.out_last = sts.dump_last;
        state_next   = S_DOUT;
      end
      S_DOUT: begin
        if (!rsp_stall) begin
          if (sts.dump_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.act    = ACT_DUMP_NEXT;
            state_next = S_DREAD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/bdeq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_dpath
// Ring store, front pointer, entry count, dump cursor and result registers.
// ----------------------------------------------------------------------------
module bdeq_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [31:0]            item_value,
  input  bdeq_pkg::cmd_t                cmd,
  output bdeq_pkg::sts_t                sts,
  output logic signed [31:0]            result_value,
  output logic [1:0]                    status,
  output logic                          last
);
  import bdeq_pkg::*;

  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

  function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
    if (s >= DEPTH_S) begin
      return IDX_W'(s - DEPTH_S);
    end
    return IDX_W'(s);
  endfunction

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;
  logic [IDX_W-1:0] front_index, front_next;
  logic [CNT_W-1:0] entry_count, count_next;
  logic [IDX_W-1:0] dump_ofs;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             wr_en, rd_en;
  logic [SUM_W-1:0] front_s, count_s, ofs_s;

  assign front_s = SUM_W'(front_index);
  assign count_s = SUM_W'(entry_count);
  assign ofs_s   = SUM_W'(dump_ofs);

  assign sts.full      = (entry_count == CNT_W'(DEPTH));
  assign sts.empty     = (entry_count == '0);
  assign sts.dump_last = ((ofs_s + SUM_W'(1)) == count_s);

  always_comb begin
    front_next = front_index;
    count_next = entry_count;
    wr_en      = 1'b0;
    wr_addr    = front_index;
    rd_en      = 1'b0;
    rd_addr    = front_index;
    unique case (cmd.act)
      ACT_PUSH_FRONT: begin
        wr_en      = 1'b1;
        wr_addr    = ring_wrap(front_s + DEPTH_S - SUM_W'(1));
        front_next = wr_addr;
        count_next = entry_count + CNT_W'(1);
      end
      ACT_PUSH_BACK: begin
        wr_en      = 1'b1;
        wr_addr    = ring_wrap(front_s + count_s);
        count_next = entry_count + CNT_W'(1);
      end
      ACT_POP_FRONT: begin
        rd_en      = 1'b1;
        rd_addr    = front_index;
        front_next = ring_wrap(front_s + SUM_W'(1));
        count_next = entry_count - CNT_W'(1);
      end
      ACT_POP_BACK: begin
        rd_en      = 1'b1;
        rd_addr    = ring_wrap(front_s + count_s - SUM_W'(1));
        count_next = entry_count - CNT_W'(1);
      end
      ACT_DUMP_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = front_index;
      end
      ACT_DUMP_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = ring_wrap(front_s + ofs_s + SUM_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      entry_count <= '0;
    end else begin
      front_index <= front_next;
      entry_count <= count_next;
    end
  end

  // dump cursor: offset from the front of the entry being read
  always_ff @(posedge clk) begin
    if (cmd.act == ACT_DUMP_FIRST) begin
      dump_ofs <= '0;
    end else if (cmd.act == ACT_DUMP_NEXT) begin
      dump_ofs <= dump_ofs + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_src)
        SRC_ECHO: result_value <= item_value;
        SRC_MEM:  result_value <= rd_data;
        default:  result_value <= '0;
      endcase
      status <= cmd.out_status;
      last   <= cmd.out_last;
    end
  end

endmodule

// File: hdl/bounded_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Double-ended queue of signed 32-bit values in a DEPTH-entry ring store:
// push/pop at either end and an ordered dump of all entries.
// ----------------------------------------------------------------------------
//
//  channel  signals                               flow control
//  -------  ------------------------------------  ------------------------
//  request  req_valid, op, item_value             req_stall from the queue
//  result   rsp_valid, result_value, status, last rsp_stall from the sink
//
//  A push loads the result register from the request; a pop first reads the
//  ring store (the read is registered) and then loads it; the result is then
//  handed over. A dump does one store read and one result hand-over per entry.
//  One request is in flight at a time; req_stall is high until its last
//  result has been taken.
//  Reset (rst, synchronous) empties the queue; the store is not cleared,
//  entries are only read once written.
//  A stalled result holds all fields steady; unused op codes give no result.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] item_value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] result_value,
  output logic [1:0]         status,
  output logic               last
);
  import bdeq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: op decode, read timing, dump stepping, result hand-over
  bdeq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // ring store, pointers and result registers
  bdeq_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item_value   (item_value),
    .cmd          (cmd),
    .sts          (sts),
    .result_value (result_value),
    .status       (status),
    .last         (last)
  );

  // no request is taken while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request accepted while a result is pending");

  // error results carry zero and end the request
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status != ST_OK)) |-> ((result_value == 0) && last))
    else $error("error result with data or without last");

  // an unused op code is dropped and leaves the queue ready
  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (op != OP_PUSH_FRONT) && (op != OP_PUSH_BACK) &&
     (op != OP_POP_FRONT) && (op != OP_POP_BACK) && (op != OP_DUMP))
    |=> (!req_stall && !rsp_valid))
    else $error("unused op code not dropped");

  // a taken final result returns the queue to ready
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && last) |=> !req_stall)
    else $error("queue not ready after final result");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded double-ended queue. A mirror of the
// ring store predicts every result of each accepted request, and each result
// handed over is checked field by field against the oldest prediction.
// A short directed run covers the empty and boundary cases, then four random
// phases fill and drain the queue under different idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
  import bdeq_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 100;
  // settle time after the last drain, before the verdict
  localparam int SETTLE_CYCLES   = 20;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
    logic             last;
  } deque_result_t;

  // Mirror of the queue: own copy of the ring, front pointer and fill level,
  // plus the results still owed by the block, oldest first.
  class deque_mirror;
    logic [VAL_W-1:0] ring [DEPTH];
    int unsigned      head;
    int unsigned      fill;
    deque_result_t    awaited_results [$];
    int unsigned      mismatches;

    function new();
      head       = 0;
      fill       = 0;
      mismatches = 0;
    endfunction

    function void owe(logic [VAL_W-1:0] value, logic [1:0] code, logic fin);
      deque_result_t r;
      r.value  = value;
      r.status = code;
      r.last   = fin;
      awaited_results.push_back(r);
    endfunction

    // Apply one accepted request and queue the results it causes.
    function void note_request(logic [2:0] code, logic [VAL_W-1:0] value);
      int unsigned i;
      case (code)
        OP_PUSH_FRONT: begin
          if (fill == DEPTH) begin
            owe('0, ST_FULL, 1'b1);
          end else begin
            head       = (head + DEPTH - 1) % DEPTH;
            ring[head] = value;
            fill++;
            owe(value, ST_OK, 1'b1);
          end
        end
        OP_PUSH_BACK: begin
          if (fill == DEPTH) begin
            owe('0, ST_FULL, 1'b1);
          end else begin
            ring[(head + fill) % DEPTH] = value;
            fill++;
            owe(value, ST_OK, 1'b1);
          end
        end
        OP_POP_FRONT: begin
          if (fill == 0) begin
            owe('0, ST_EMPTY, 1'b1);
          end else begin
            owe(ring[head], ST_OK, 1'b1);
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
        OP_POP_BACK: begin
          if (fill == 0) begin
            owe('0, ST_EMPTY, 1'b1);
          end else begin
            owe(ring[(head + fill - 1) % DEPTH], ST_OK, 1'b1);
            fill--;
          end
        end
        OP_DUMP: begin
          if (fill == 0) begin
            owe('0, ST_EMPTY, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) begin
              owe(ring[(head + i) % DEPTH], ST_OK, (i + 1 == fill));
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(logic [VAL_W-1:0] value, logic [1:0] code, logic fin);
      deque_result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h status %0d last %0d",
                 $time, value, code, fin);
      end else begin
        want = awaited_results.pop_front();
        if (value !== want.value) report("result_value", want.value, value);
        if (code !== want.status) report("status", 32'(want.status), 32'(code));
        if (fin !== want.last) report("last", 32'(want.last), 32'(fin));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block connections; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst        = 1'b1;
  logic               req_valid  = 1'b0;
  logic               req_stall;
  logic [2:0]         op         = '0;
  logic signed [31:0] item_value = '0;
  logic               rsp_valid;
  logic               rsp_stall  = 1'b0;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic               last;

  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  int unsigned cycle_count        = 0;
  // random traffic alternates between filling the queue and draining it
  bit          filling_up         = 1'b1;

  deque_mirror mirror = new();

  bounded_double_ended_queue dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .op           (op),
    .item_value   (item_value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_value (result_value),
    .status       (status),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Sink side: stall at random, at the rate the current phase asks for.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // A result is taken at an edge where valid is high and we are not stalling.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      mirror.check_result(result_value, status, last);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Offer one request, holding it steady until the queue accepts it. Idle
  // cycles before it are drawn per cycle; valid only drops when a gap is due,
  // so back-to-back requests never see valid lowered and raised in one step.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] code, input logic [31:0] value);
    if ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    req_valid  <= 1'b1;
    op         <= code;
    item_value <= value;
    do @(posedge clk); while (req_stall);
    mirror.note_request(code, value);
  endtask

  // Hold off new requests until every owed result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (mirror.awaited_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // One random phase. Mostly pushes while filling and pops while draining, so
  // the queue keeps hitting both full and empty; the mode flips at random once
  // a boundary is reached. Dumps are kept rare since each costs a result per
  // entry. Unused op codes are thrown in as noise and not counted.
  // --------------------------------------------------------------------------
  task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
    int          sent;
    int          roll;
    int          push_share;
    logic [2:0]  code;
    logic [31:0] value;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      if (mirror.fill == DEPTH && $urandom_range(2) == 0) filling_up = 1'b0;
      if (mirror.fill == 0 && $urandom_range(2) == 0) filling_up = 1'b1;
      case ($urandom_range(9))
        0:       value = 32'h7fff_ffff;
        1:       value = 32'h8000_0000;
        2:       value = 32'h0000_0000;
        3:       value = 32'hffff_ffff;
        default: value = $urandom;
      endcase
      push_share = filling_up ? 80 : 20;
      roll = $urandom_range(99);
      if ($urandom_range(99) < 3) begin
        code = OP_DUMP + 3'($urandom_range(1, 3));
      end else if (roll < 6) begin
        code = OP_DUMP;
      end else if (roll < 6 + push_share / 2) begin
        code = OP_PUSH_FRONT;
      end else if (roll < 6 + push_share) begin
        code = OP_PUSH_BACK;
      end else if (roll < 6 + push_share + (94 - push_share) / 2) begin
        code = OP_POP_FRONT;
      end else begin
        code = OP_POP_BACK;
      end
      send_request(code, value);
      if (code <= OP_DUMP) sent++;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases first, then value extremes at both ends, then
    // unused codes between real requests and a walk back down to empty.
    send_request(OP_POP_FRONT,  32'h1234_5678);
    send_request(OP_POP_BACK,   32'hdead_beef);
    send_request(OP_DUMP,       32'hffff_ffff);
    send_request(3'd5,          32'h0000_0001);
    send_request(OP_PUSH_BACK,  32'h7fff_ffff);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_PUSH_BACK,  32'hffff_ffff);
    send_request(OP_PUSH_FRONT, 32'h0000_0000);
    send_request(OP_DUMP,       32'h0000_0000);
    send_request(3'd6,          32'h5555_5555);
    send_request(OP_POP_BACK,   32'h0000_0000);
    send_request(OP_POP_FRONT,  32'h0000_0000);
    send_request(OP_DUMP,       32'haaaa_aaaa);
    send_request(3'd7,          32'hffff_ffff);
    send_request(OP_POP_FRONT,  32'h0000_0000);
    send_request(OP_POP_BACK,   32'h0000_0000);
    send_request(OP_POP_BACK,   32'h0000_0000);
    send_request(OP_PUSH_BACK,  32'haaaa_aaaa);
    send_request(OP_PUSH_FRONT, 32'h5555_5555);
    send_request(OP_DUMP,       32'h0000_0000);
    send_request(OP_POP_FRONT,  32'h0000_0000);
    send_request(OP_POP_FRONT,  32'h0000_0000);
    send_request(OP_DUMP,       32'h0000_0000);
    drain_results();

    // Random phases; each is followed by a full drain before the next.
    run_phase(0, 0, ITEMS_PER_PHASE);
    drain_results();
    run_phase(87, 0, ITEMS_PER_PHASE);
    drain_results();
    run_phase(0, 87, ITEMS_PER_PHASE);
    drain_results();
    run_phase(32, 32, ITEMS_PER_PHASE);
    drain_results();

    // Give any stray result time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
